@@ rtl/dsq_pkg.sv @@
// Shared types, constants and the exponential node table of the depth sample quantizer.
// Used by every module of the block; depends on nothing else.
package dsq_pkg;

  localparam int EXP_TABLE_BITS = 10;
  localparam int EXP_SHIFT      = 24 - EXP_TABLE_BITS;
  localparam int EXP_NODES      = (1 << EXP_TABLE_BITS) + 1;
  localparam int EXP_IDX_W      = EXP_TABLE_BITS + 1;

  localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] LN2_Q32   = 64'd2977044472;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [24:0] ONE_Q24   = 25'h100_0000;
  localparam logic [32:0] ONE_E     = 33'h1_0000_0000;
  localparam logic [8:0]  EXP_MAX_SHIFT = 9'd40;

  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;
  localparam int DIV_STEP  = 2;
  localparam int DIV_STAGES = 32 / DIV_STEP;

  typedef enum logic [2:0] {
    REG_USER_SCALE = 3'd0,
    REG_USER_BIAS  = 3'd1,
    REG_HW_RECIP   = 3'd2,
    REG_HW_BIAS    = 3'd3,
    REG_LOG_SCALE  = 3'd4,
    REG_OUT_BYTES  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_ZERO   = 2'd0,
    KIND_MAX    = 2'd1,
    KIND_LINEAR = 2'd2,
    KIND_CURVE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [23:0] user_scale;
    logic signed [31:0] user_bias;
    logic signed [23:0] hw_scale_recip;
    logic signed [31:0] hw_bias;
    logic signed [15:0] log_scale;
    logic [2:0]         out_bytes;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [23:0] ux;
    logic [31:0] arg_a;
  } q_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] lin;
  } tag_t;

  typedef logic [32:0] node_t;
  typedef node_t node_tab_t [EXP_NODES];

  function automatic logic [31:0] max_code(input logic [2:0] ob);
    logic [31:0] m;
    case (ob)
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      3'd4:    m = 32'hFFFF_FFFF;
      default: m = 32'h0000_00FF;
    endcase
    return m;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic node_t pow2neg_node(input logic [63:0] t);
    logic [63:0]        g;
    logic [63:0]        term;
    logic signed [65:0] sum;
    g    = (t * LN2_Q32) >> 24;
    term = ONE_Q32;
    sum  = 66'(ONE_Q32);
    for (int n = 1; n <= 12; n++) begin
      term = (term * g) >> 32;
      case (n)
        1:       term = term / 1;
        2:       term = term / 2;
        3:       term = term / 3;
        4:       term = term / 4;
        5:       term = term / 5;
        6:       term = term / 6;
        7:       term = term / 7;
        8:       term = term / 8;
        9:       term = term / 9;
        10:      term = term / 10;
        11:      term = term / 11;
        default: term = term / 12;
      endcase
      if (n % 2 == 1) begin
        sum = sum - $signed({2'b00, term});
      end else begin
        sum = sum + $signed({2'b00, term});
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    return node_t'(sum);
  endfunction

  function automatic node_tab_t build_nodes();
    node_tab_t tab;
    for (int i = 0; i < EXP_NODES; i++) begin
      tab[i] = pow2neg_node(64'(i) << EXP_SHIFT);
    end
    return tab;
  endfunction

  localparam node_tab_t EXP_NODE = build_nodes();

endpackage

@@ rtl/dsq_front.sv @@
// Front part: user scale and bias, range correction, and classification of each sample.
// Depends on dsq_pkg; feeds dsq_queue.
module dsq_front import dsq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] sample,
  output logic               push,
  output q_item_t            item,
  input  logic               q_full
);

  logic               en;
  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [55:0] p1_r;
  logic signed [31:0] t1_r;
  logic signed [55:0] p2_r;
  logic signed [31:0] x_r;
  q_item_t            item_r;

  logic signed [47:0] sum1;
  logic signed [47:0] sum2;
  logic [15:0]        mag;
  logic [24:0]        sel;
  logic [40:0]        prod;
  q_item_t            item_nxt;

  assign en       = !(v5_r && q_full);
  assign in_ready = en;
  assign push     = v5_r && !q_full;
  assign item     = item_r;

  always_comb begin
    sum1 = 48'(p1_r >>> 16) + 48'(cfg.user_bias);
    sum2 = 48'(p2_r >>> 16) - 48'(cfg.hw_bias);
    mag  = cfg.log_scale[15] ? 16'(~cfg.log_scale + 16'sd1) : cfg.log_scale;
    sel  = cfg.log_scale[15] ? {1'b0, x_r[23:0]} : 25'(ONE_Q24 - 25'(x_r[23:0]));
    prod = 41'(mag) * 41'(sel);
    item_nxt.ux    = x_r[23:0];
    item_nxt.arg_a = prod[39:8];
    if (x_r[31] || x_r == 32'sd0) begin
      item_nxt.kind = KIND_ZERO;
    end else if (x_r[30:24] != 7'd0) begin
      item_nxt.kind = KIND_MAX;
    end else if (cfg.log_scale == 16'sd0) begin
      item_nxt.kind = KIND_LINEAR;
    end else begin
      item_nxt.kind = KIND_CURVE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
    if (en) begin
      p1_r   <= 56'(sample) * 56'(cfg.user_scale);
      t1_r   <= sat32(sum1);
      p2_r   <= 56'(t1_r) * 56'(cfg.hw_scale_recip);
      x_r    <= sat32(sum2);
      item_r <= item_nxt;
    end
  end

endmodule

@@ rtl/dsq_queue.sv @@
// Short queue that decouples the front part from the back part.
// Depends on dsq_pkg.
module dsq_queue import dsq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    valid,
  output q_item_t pop_item
);

  q_item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_r, rd_r;
  logic [Q_CNT_W-1:0]   cnt_r;

  assign full     = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_item = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule

@@ rtl/dsq_exp.sv @@
// Four-stage e^-a unit: base change, node table read, interpolation and power-of-two shift.
// Depends on dsq_pkg for the node table.
module dsq_exp import dsq_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] arg,
  output logic [32:0] value
);

  logic [62:0]                 prod_r;
  node_t                       lo_r, hi_r, lo3_r;
  logic [EXP_SHIFT-1:0]        r_r;
  logic [8:0]                  ip_r, ip3_r;
  logic                        le_r;
  logic [32+EXP_SHIFT:0]       dp_r;
  logic [32:0]                 value_r;

  logic [EXP_IDX_W-1:0]        idx;
  logic [32:0]                 v;

  assign idx   = {1'b0, prod_r[53:30+EXP_SHIFT]};
  assign value = value_r;

  always_comb begin
    if (le_r) begin
      v = lo3_r;
    end else begin
      v = lo3_r - 33'(dp_r >> EXP_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= 63'(arg) * 63'(LOG2E_Q30);
      lo_r    <= EXP_NODE[idx];
      hi_r    <= EXP_NODE[idx + 1'b1];
      r_r     <= prod_r[30+EXP_SHIFT-1:30];
      ip_r    <= prod_r[62:54];
      le_r    <= (lo_r <= hi_r);
      dp_r    <= (33+EXP_SHIFT)'(lo_r - hi_r) * (33+EXP_SHIFT)'(r_r);
      lo3_r   <= lo_r;
      ip3_r   <= ip_r;
      value_r <= (ip3_r >= EXP_MAX_SHIFT) ? 33'd0 : (v >> ip3_r);
    end
  end

endmodule

@@ rtl/dsq_div.sv @@
// Pipelined restoring divider giving floor(num * 2^32 / den) for num below den.
// Depends on dsq_pkg; carries a tag alongside each quotient.
module dsq_div import dsq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] num,
  input  logic [32:0] den,
  input  tag_t        in_tag,
  output logic        out_valid,
  output logic [31:0] quo,
  output tag_t        out_tag
);

  logic        vld_w [DIV_STAGES+1];
  logic [32:0] rem_w [DIV_STAGES+1];
  logic [32:0] den_w [DIV_STAGES+1];
  logic [31:0] quo_w [DIV_STAGES+1];
  tag_t        tag_w [DIV_STAGES+1];

  assign vld_w[0] = in_valid;
  assign rem_w[0] = {1'b0, num};
  assign den_w[0] = den;
  assign quo_w[0] = '0;
  assign tag_w[0] = in_tag;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [32:0] rem_nxt;
    logic [31:0] quo_nxt;
    logic [33:0] sh;
    logic        vld_r;
    logic [32:0] rem_r, den_r;
    logic [31:0] quo_r;
    tag_t        tag_r;

    always_comb begin
      rem_nxt = rem_w[g];
      quo_nxt = quo_w[g];
      sh      = '0;
      for (int s = 0; s < DIV_STEP; s++) begin
        sh = {rem_nxt, 1'b0};
        if (sh >= {1'b0, den_w[g]}) begin
          rem_nxt = 33'(sh - {1'b0, den_w[g]});
          quo_nxt = {quo_nxt[30:0], 1'b1};
        end else begin
          rem_nxt = sh[32:0];
          quo_nxt = {quo_nxt[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_w[g];
      end
      if (en) begin
        rem_r <= rem_nxt;
        den_r <= den_w[g];
        quo_r <= quo_nxt;
        tag_r <= tag_w[g];
      end
    end

    assign vld_w[g+1] = vld_r;
    assign rem_w[g+1] = rem_r;
    assign den_w[g+1] = den_r;
    assign quo_w[g+1] = quo_r;
    assign tag_w[g+1] = tag_r;
  end

  assign out_valid = vld_w[DIV_STAGES];
  assign quo       = quo_w[DIV_STAGES];
  assign out_tag   = tag_w[DIV_STAGES];

endmodule

@@ rtl/dsq_back.sv @@
// Back part: exponential curve, ratio division, scaling to the code range and output register.
// Depends on dsq_pkg, dsq_exp and dsq_div.
module dsq_back import dsq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  q_item_t     q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_code
);

  localparam int EXP_LAT = 4;

  typedef struct packed {
    logic  vld;
    kind_t kind;
    logic [31:0] lin;
  } sb_t;

  logic        en;
  logic [31:0] maxv;
  logic [15:0] mag;
  logic [31:0] arg_b;
  logic [32:0] ea, eb;
  logic [55:0] lin_prod;
  sb_t         sb_r [EXP_LAT];

  logic        d_vld_r;
  logic [31:0] num_r;
  logic [32:0] den_r;
  tag_t        d_tag_r;

  logic [32:0] num_c, den_c;
  tag_t        tag_c;

  logic        q_vld;
  logic [31:0] quo;
  tag_t        q_tag;

  logic        m_vld_r;
  logic [63:0] prod_r;
  tag_t        m_tag_r;

  logic        out_vld_r;
  logic [31:0] code_r;
  logic [31:0] code_nxt;

  assign en        = !out_vld_r || out_ready;
  assign q_pop     = en && q_valid;
  assign maxv      = max_code(cfg.out_bytes);
  assign mag       = cfg.log_scale[15] ? 16'(~cfg.log_scale + 16'sd1) : cfg.log_scale;
  assign arg_b     = {mag, 16'h0000};
  assign lin_prod  = 56'(q_item.ux) * 56'(maxv);
  assign out_valid = out_vld_r;
  assign out_code  = code_r;

  dsq_exp u_exp_a (.clk(clk), .en(en), .arg(q_item.arg_a), .value(ea));
  dsq_exp u_exp_b (.clk(clk), .en(en), .arg(arg_b),        .value(eb));

  always_comb begin
    if (!cfg.log_scale[15]) begin
      num_c = (ea > eb) ? 33'(ea - eb) : 33'd0;
    end else begin
      num_c = (ea < ONE_E) ? 33'(ONE_E - ea) : 33'd0;
    end
    den_c      = 33'(ONE_E - eb);
    tag_c.lin  = sb_r[EXP_LAT-1].lin;
    tag_c.kind = sb_r[EXP_LAT-1].kind;
    if (sb_r[EXP_LAT-1].kind == KIND_CURVE) begin
      if (eb >= ONE_E) begin
        tag_c.kind = KIND_LINEAR;
      end else if (num_c >= den_c) begin
        tag_c.kind = KIND_MAX;
      end
    end
  end

  dsq_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(d_vld_r), .num(num_r), .den(den_r), .in_tag(d_tag_r),
    .out_valid(q_vld), .quo(quo), .out_tag(q_tag)
  );

  always_comb begin
    case (m_tag_r.kind)
      KIND_ZERO:   code_nxt = 32'd0;
      KIND_MAX:    code_nxt = maxv;
      KIND_LINEAR: code_nxt = m_tag_r.lin;
      default:     code_nxt = prod_r[63:32];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < EXP_LAT; i++) begin
        sb_r[i].vld <= 1'b0;
      end
      d_vld_r   <= 1'b0;
      m_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      sb_r[0].vld <= q_valid;
      for (int i = 1; i < EXP_LAT; i++) begin
        sb_r[i].vld <= sb_r[i-1].vld;
      end
      d_vld_r   <= sb_r[EXP_LAT-1].vld;
      m_vld_r   <= q_vld;
      out_vld_r <= m_vld_r;
    end
    if (en) begin
      sb_r[0].kind <= q_item.kind;
      sb_r[0].lin  <= lin_prod[55:24];
      for (int i = 1; i < EXP_LAT; i++) begin
        sb_r[i].kind <= sb_r[i-1].kind;
        sb_r[i].lin  <= sb_r[i-1].lin;
      end
      num_r   <= num_c[31:0];
      den_r   <= den_c;
      d_tag_r <= tag_c;
      prod_r  <= 64'(quo) * 64'(maxv);
      m_tag_r <= q_tag;
      code_r  <= code_nxt;
    end
  end

endmodule

@@ rtl/depth_sample_quantizer.sv @@
// Depth sample quantizer: one signed Q8.24 depth sample in, one unsigned depth code out.
// Throughput is one sample per cycle while the output is not stalled, carried by a fully
// pipelined datapath whose longest part is the 16-stage divider of the curve ratio,
// two quotient bits per stage.
// Reset is synchronous and active low; it empties the pipeline and queue and restores
// the register defaults.
module depth_sample_quantizer import dsq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] depth_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] depth_code
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t    cfg_r;
  logic    push, q_full, q_valid, q_pop;
  q_item_t push_item, pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.user_scale     <= 24'sd65536;
      cfg_r.user_bias      <= 32'sd0;
      cfg_r.hw_scale_recip <= 24'sd65536;
      cfg_r.hw_bias        <= 32'sd0;
      cfg_r.log_scale      <= 16'sd8192;
      cfg_r.out_bytes      <= 3'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_USER_SCALE: cfg_r.user_scale     <= cfg_data[23:0];
        REG_USER_BIAS:  cfg_r.user_bias      <= cfg_data;
        REG_HW_RECIP:   cfg_r.hw_scale_recip <= cfg_data[23:0];
        REG_HW_BIAS:    cfg_r.hw_bias        <= cfg_data;
        REG_LOG_SCALE:  cfg_r.log_scale      <= cfg_data[15:0];
        REG_OUT_BYTES:  cfg_r.out_bytes      <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  dsq_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_tvalid), .in_ready(in_tready), .sample(in_tdata),
    .push(push), .item(push_item), .q_full(q_full)
  );

  dsq_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_item(push_item), .full(q_full),
    .pop(q_pop), .valid(q_valid), .pop_item(pop_item)
  );

  dsq_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_valid(q_valid), .q_item(pop_item), .q_pop(q_pop),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_code(out_tdata)
  );

endmodule
